@@ src/mouse_control_report_responder_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the command report responder
// Immediate-consequence and next-cycle property wrappers.
// ----------------------------------------------------------------------------
`ifndef MOUSE_CONTROL_REPORT_RESPONDER_TOP_ASSERT_SVH
`define MOUSE_CONTROL_REPORT_RESPONDER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MCRR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define MCRR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mcrr_pkg.sv @@
// ----------------------------------------------------------------------------
// mcrr_pkg
// Constants, codes and shared types of the command report responder.
// ----------------------------------------------------------------------------
package mcrr_pkg;

  localparam int unsigned REPORT_BYTES    = 90;
  localparam int unsigned MAX_STAGES_DEF  = 5;
  localparam int unsigned OFF_W           = 7;
  localparam int unsigned CHECK_POS       = 88;
  localparam int unsigned LAST_POS        = 89;
  localparam int unsigned XOR_FIRST       = 2;
  localparam int unsigned CLS_POS         = 6;
  localparam int unsigned ID_POS          = 7;
  localparam int unsigned ARG_BASE        = 8;
  localparam int unsigned REC_BASE        = 11;
  localparam int unsigned REC_LEN         = 7;
  localparam int unsigned REC_W           = 56;
  localparam int unsigned REC_CNT_W       = 4;

  localparam logic [7:0] CLS_SYS       = 8'h00;
  localparam logic [7:0] CLS_DPI       = 8'h04;
  localparam logic [7:0] ID_FW_GET     = 8'h81;
  localparam logic [7:0] ID_POLL_GET   = 8'hc0;
  localparam logic [7:0] ID_POLL_SET   = 8'h40;
  localparam logic [7:0] ID_DPI_GET    = 8'h85;
  localparam logic [7:0] ID_DPI_SET    = 8'h05;
  localparam logic [7:0] ID_STAGE_GET  = 8'h86;
  localparam logic [7:0] ID_STAGE_SET  = 8'h06;
  localparam logic [7:0] POLL_MAX      = 8'h40;

  localparam logic [7:0] WIRE_SUCCESS  = 8'h02;
  localparam logic [7:0] WIRE_FAILURE  = 8'h03;
  localparam logic [7:0] WIRE_UNSUP    = 8'h05;

  localparam logic [1:0] STAT_NONE     = 2'd0;
  localparam logic [1:0] STAT_SUCCESS  = 2'd1;
  localparam logic [1:0] STAT_FAILURE  = 2'd2;
  localparam logic [1:0] STAT_UNSUP    = 2'd3;

  localparam logic       CFG_FW_MAJOR  = 1'b0;
  localparam logic       CFG_FW_MINOR  = 1'b1;

  localparam logic [7:0]  FW_MAJOR_RST  = 8'd1;
  localparam logic [7:0]  FW_MINOR_RST  = 8'd2;
  localparam logic [7:0]  POLL_RST      = 8'h08;
  localparam logic [15:0] DPI_RST       = 16'd800;
  localparam logic [7:0]  ACTIVE_RST    = 8'd1;
  localparam int unsigned STAGE_CNT_RST = 5;

  typedef enum logic [2:0] {
    CMD_NONE, CMD_FW_GET, CMD_POLL_GET, CMD_POLL_SET,
    CMD_DPI_GET, CMD_DPI_SET, CMD_STAGE_GET, CMD_STAGE_SET
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD_WAIT, ST_CHECK, ST_DRAIN, ST_BUILD, ST_FLUSH, ST_RESULT
  } state_e;

  typedef struct packed {
    logic start_check;
    logic decide;
    logic issue;
    logic build_phase;
    logic pend_wr;
    logic pend_rd;
    logic pend_ex;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic check_last;
    logic build_last;
    logic out_free;
  } ctrl_stat_t;

  function automatic logic rate_ok(input logic [7:0] c);
    return (c != 8'h00) && ((c & (c - 8'h01)) == 8'h00) && (c <= POLL_MAX);
  endfunction

  function automatic cmd_e decode(input logic [7:0] cls, input logic [7:0] id);
    cmd_e r;
    r = CMD_NONE;
    if (cls == CLS_SYS) begin
      if (id == ID_FW_GET)        r = CMD_FW_GET;
      else if (id == ID_POLL_GET) r = CMD_POLL_GET;
      else if (id == ID_POLL_SET) r = CMD_POLL_SET;
    end else if (cls == CLS_DPI) begin
      if (id == ID_DPI_GET)         r = CMD_DPI_GET;
      else if (id == ID_DPI_SET)    r = CMD_DPI_SET;
      else if (id == ID_STAGE_GET)  r = CMD_STAGE_GET;
      else if (id == ID_STAGE_SET)  r = CMD_STAGE_SET;
    end
    return r;
  endfunction

endpackage

@@ src/mcrr_if.sv @@
// ----------------------------------------------------------------------------
// mcrr request and response channels
// Valid/ready channels carrying byte accesses and their results.
// ----------------------------------------------------------------------------
interface mcrr_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [6:0] offset;
  logic [7:0] wdata;
  modport source (output valid, kind, offset, wdata, input ready);
  modport sink   (input valid, kind, offset, wdata, output ready);
endinterface

interface mcrr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       executed;
  logic [1:0] cmd_status;
  modport source (output valid, rdata, executed, cmd_status, input ready);
  modport sink   (input valid, rdata, executed, cmd_status, output ready);
endinterface

@@ src/mcrr_ram.sv @@
// ----------------------------------------------------------------------------
// mcrr_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcrr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 90,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/mcrr_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcrr_ctrl
// Sequencer: accepts requests, runs the check and build walks, hands results.
// ----------------------------------------------------------------------------
module mcrr_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_kind_i,
  input  logic [6:0]             in_offset_i,
  output logic                   in_ready_o,
  input  mcrr_pkg::ctrl_stat_t   stat_i,
  output mcrr_pkg::ctrl_cmd_t    cmd_o
);

  mcrr_pkg::state_e state_q, state_d;
  logic acc, final_wr;

  assign acc      = in_valid_i && (state_q == mcrr_pkg::ST_IDLE);
  assign final_wr = !in_kind_i &&
                    (in_offset_i == mcrr_pkg::OFF_W'(mcrr_pkg::LAST_POS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcrr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mcrr_pkg::ST_IDLE: begin
        if (acc) begin
          if (in_kind_i)     state_d = mcrr_pkg::ST_RD_WAIT;
          else if (final_wr) state_d = mcrr_pkg::ST_CHECK;
          else               state_d = mcrr_pkg::ST_RESULT;
        end
      end
      mcrr_pkg::ST_RD_WAIT: state_d = mcrr_pkg::ST_RESULT;
      mcrr_pkg::ST_CHECK: begin
        if (stat_i.check_last) state_d = mcrr_pkg::ST_DRAIN;
      end
      mcrr_pkg::ST_DRAIN: state_d = mcrr_pkg::ST_BUILD;
      mcrr_pkg::ST_BUILD: begin
        if (stat_i.build_last) state_d = mcrr_pkg::ST_FLUSH;
      end
      mcrr_pkg::ST_FLUSH: state_d = mcrr_pkg::ST_RESULT;
      mcrr_pkg::ST_RESULT: begin
        if (stat_i.out_free) state_d = mcrr_pkg::ST_IDLE;
      end
      default: state_d = mcrr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mcrr_pkg::ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.start_check = acc && final_wr;
        cmd_o.pend_wr     = acc && !in_kind_i && !final_wr;
      end
      mcrr_pkg::ST_RD_WAIT: cmd_o.pend_rd = 1'b1;
      mcrr_pkg::ST_CHECK:   cmd_o.issue   = 1'b1;
      mcrr_pkg::ST_DRAIN:   cmd_o.decide  = 1'b1;
      mcrr_pkg::ST_BUILD: begin
        cmd_o.issue       = 1'b1;
        cmd_o.build_phase = 1'b1;
      end
      mcrr_pkg::ST_FLUSH:   cmd_o.pend_ex  = 1'b1;
      mcrr_pkg::ST_RESULT:  cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

@@ src/mcrr_dp.sv @@
// ----------------------------------------------------------------------------
// mcrr_dp
// Buffers, device state, checksum and response byte builder.
// ----------------------------------------------------------------------------
module mcrr_dp #(
  parameter int unsigned MAX_STAGES = mcrr_pkg::MAX_STAGES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_accept_i,
  input  logic                 in_kind_i,
  input  logic [6:0]           in_offset_i,
  input  logic [7:0]           in_wdata_i,
  input  mcrr_pkg::ctrl_cmd_t  cmd_i,
  output mcrr_pkg::ctrl_stat_t stat_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [7:0]           out_rdata_o,
  output logic                 out_executed_o,
  output logic [1:0]           out_cmd_status_o
);

  localparam int unsigned OW   = mcrr_pkg::OFF_W;
  localparam int unsigned CntW = ($clog2(MAX_STAGES + 1) > 3) ? $clog2(MAX_STAGES + 1) : 3;
  localparam int unsigned IdxW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int unsigned REC_CNT_W_L = mcrr_pkg::REC_CNT_W;

  logic          in_range;
  logic [7:0]    req_rd, resp_rd, resp_byte;
  logic [OW-1:0] cnt_q;
  logic          p_valid_q, p_build_q;
  logic [OW-1:0] p_addr_q;
  logic          proc_chk, proc_build, p_in_xor;
  logic [7:0]    xor_q;
  logic [7:0]    cls_q, id_q, a1_q, a2_q, a3_q, a4_q;
  mcrr_pkg::cmd_e cmd_q, dec_cmd, eff_cmd;
  logic [1:0]    st_q, st_d;
  logic          crc_ok;
  logic [7:0]    fw_major_q, fw_minor_q, poll_q, active_q;
  logic [15:0]   dpi_x_q, dpi_y_q;
  logic [CntW-1:0] stage_cnt_q;
  logic [REC_CNT_W_L-1:0] rec_q;
  logic [2:0]    byte_q;
  logic          rec_ok;
  logic [5:0]    rec_sh;
  logic [mcrr_pkg::REC_W-1:0] rec_sel;
  logic [mcrr_pkg::REC_W-1:0] stage_rec_q [MAX_STAGES];
  logic          hold_rng_q, resp_ok_q;
  logic [7:0]    pend_rdata_q;
  logic          pend_exec_q;
  logic [1:0]    pend_stat_q;
  logic          out_valid_q;
  logic [7:0]    out_rdata_q;
  logic          out_exec_q;
  logic [1:0]    out_stat_q;
  logic [7:0]    wire_stat;

  assign in_range = in_offset_i < OW'(mcrr_pkg::REPORT_BYTES);

  mcrr_ram #(.WIDTH(8), .DEPTH(mcrr_pkg::REPORT_BYTES)) u_req_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept_i && !in_kind_i && in_range),
    .waddr_i (in_offset_i),
    .wdata_i (in_wdata_i),
    .raddr_i (cnt_q),
    .rdata_o (req_rd)
  );

  mcrr_ram #(.WIDTH(8), .DEPTH(mcrr_pkg::REPORT_BYTES)) u_rsp_ram (
    .clk_i   (clk_i),
    .we_i    (proc_build),
    .waddr_i (p_addr_q),
    .wdata_i (resp_byte),
    .raddr_i (in_offset_i),
    .rdata_o (resp_rd)
  );

  assign proc_chk   = p_valid_q && !p_build_q;
  assign proc_build = p_valid_q && p_build_q;
  assign p_in_xor   = (p_addr_q >= OW'(mcrr_pkg::XOR_FIRST)) &&
                      (p_addr_q < OW'(mcrr_pkg::CHECK_POS));

  assign stat_o.check_last = cnt_q == OW'(mcrr_pkg::CHECK_POS);
  assign stat_o.build_last = cnt_q == OW'(mcrr_pkg::LAST_POS);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // walk counter and read pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      p_valid_q <= 1'b0;
      p_build_q <= 1'b0;
    end else begin
      if (cmd_i.start_check)  cnt_q <= OW'(mcrr_pkg::XOR_FIRST);
      else if (cmd_i.decide)  cnt_q <= '0;
      else if (cmd_i.issue)   cnt_q <= cnt_q + OW'(1);
      p_valid_q <= cmd_i.issue;
      p_build_q <= cmd_i.build_phase;
    end
  end

  always_ff @(posedge clk_i) begin
    p_addr_q <= cnt_q;
    if (proc_chk) begin
      if (p_addr_q == OW'(mcrr_pkg::CLS_POS))      cls_q <= req_rd;
      if (p_addr_q == OW'(mcrr_pkg::ID_POS))       id_q  <= req_rd;
      if (p_addr_q == OW'(mcrr_pkg::ARG_BASE + 1)) a1_q  <= req_rd;
      if (p_addr_q == OW'(mcrr_pkg::ARG_BASE + 2)) a2_q  <= req_rd;
      if (p_addr_q == OW'(mcrr_pkg::ARG_BASE + 3)) a3_q  <= req_rd;
      if (p_addr_q == OW'(mcrr_pkg::ARG_BASE + 4)) a4_q  <= req_rd;
    end
  end

  // decision: checksum, decode, argument checks
  assign crc_ok  = xor_q == req_rd;
  assign dec_cmd = mcrr_pkg::decode(cls_q, id_q);

  always_comb begin
    st_d = mcrr_pkg::STAT_SUCCESS;
    if (!crc_ok) begin
      st_d = mcrr_pkg::STAT_FAILURE;
    end else begin
      case (dec_cmd)
        mcrr_pkg::CMD_NONE: st_d = mcrr_pkg::STAT_UNSUP;
        mcrr_pkg::CMD_POLL_SET: begin
          if (!mcrr_pkg::rate_ok(a1_q)) st_d = mcrr_pkg::STAT_FAILURE;
        end
        mcrr_pkg::CMD_STAGE_SET: begin
          if (a2_q == 8'd0 || a2_q > 8'(MAX_STAGES)) st_d = mcrr_pkg::STAT_FAILURE;
        end
        default: ;
      endcase
    end
    eff_cmd = (st_d == mcrr_pkg::STAT_SUCCESS) ? dec_cmd : mcrr_pkg::CMD_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q       <= '0;
      st_q        <= mcrr_pkg::STAT_NONE;
      cmd_q       <= mcrr_pkg::CMD_NONE;
      fw_major_q  <= mcrr_pkg::FW_MAJOR_RST;
      fw_minor_q  <= mcrr_pkg::FW_MINOR_RST;
      poll_q      <= mcrr_pkg::POLL_RST;
      active_q    <= mcrr_pkg::ACTIVE_RST;
      dpi_x_q     <= mcrr_pkg::DPI_RST;
      dpi_y_q     <= mcrr_pkg::DPI_RST;
      stage_cnt_q <= CntW'(mcrr_pkg::STAGE_CNT_RST);
      rec_q       <= '0;
      byte_q      <= '0;
      resp_ok_q   <= 1'b0;
      hold_rng_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == mcrr_pkg::CFG_FW_MAJOR) fw_major_q <= cfg_wdata_i;
        if (cfg_idx_i == mcrr_pkg::CFG_FW_MINOR) fw_minor_q <= cfg_wdata_i;
      end
      if (in_accept_i) hold_rng_q <= in_range;
      if (cmd_i.pend_ex) resp_ok_q <= 1'b1;

      if (cmd_i.start_check || cmd_i.decide) begin
        xor_q <= '0;
      end else if (proc_chk && p_in_xor) begin
        xor_q <= xor_q ^ req_rd;
      end else if (proc_build && p_in_xor) begin
        xor_q <= xor_q ^ resp_byte;
      end

      if (cmd_i.decide) begin
        st_q   <= st_d;
        cmd_q  <= eff_cmd;
        rec_q  <= '0;
        byte_q <= '0;
        case (eff_cmd)
          mcrr_pkg::CMD_POLL_SET: poll_q <= a1_q;
          mcrr_pkg::CMD_DPI_SET: begin
            dpi_x_q <= {a1_q, a2_q};
            dpi_y_q <= {a3_q, a4_q};
          end
          mcrr_pkg::CMD_STAGE_SET: begin
            active_q    <= a1_q;
            stage_cnt_q <= a2_q[CntW-1:0];
          end
          default: ;
        endcase
      end else if (proc_build && p_addr_q >= OW'(mcrr_pkg::REC_BASE)) begin
        if (byte_q == 3'(mcrr_pkg::REC_LEN - 1)) begin
          byte_q <= '0;
          if (rec_q != '1) rec_q <= rec_q + REC_CNT_W_L'(1);
        end else begin
          byte_q <= byte_q + 3'd1;
        end
      end
    end
  end

  // stage record table
  assign rec_ok  = (8'(rec_q) < 8'(MAX_STAGES)) && (8'(rec_q) < 8'(stage_cnt_q));
  assign rec_sh  = {3'(mcrr_pkg::REC_LEN - 1) - byte_q, 3'b000};
  assign rec_sel = stage_rec_q[rec_q[IdxW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_STAGES; i++) stage_rec_q[i] <= '0;
    end else if (proc_build && cmd_q == mcrr_pkg::CMD_STAGE_SET && rec_ok &&
                 p_addr_q >= OW'(mcrr_pkg::REC_BASE)) begin
      stage_rec_q[rec_q[IdxW-1:0]][rec_sh +: 8] <= req_rd;
    end
  end

  // response byte builder
  always_comb begin
    case (st_q)
      mcrr_pkg::STAT_SUCCESS: wire_stat = mcrr_pkg::WIRE_SUCCESS;
      mcrr_pkg::STAT_FAILURE: wire_stat = mcrr_pkg::WIRE_FAILURE;
      default:                wire_stat = mcrr_pkg::WIRE_UNSUP;
    endcase
  end

  always_comb begin
    resp_byte = req_rd;
    case (cmd_q)
      mcrr_pkg::CMD_FW_GET: begin
        if (p_addr_q == OW'(mcrr_pkg::ARG_BASE))     resp_byte = fw_major_q;
        if (p_addr_q == OW'(mcrr_pkg::ARG_BASE + 1)) resp_byte = fw_minor_q;
      end
      mcrr_pkg::CMD_POLL_GET: begin
        if (p_addr_q == OW'(mcrr_pkg::ARG_BASE + 1)) resp_byte = poll_q;
      end
      mcrr_pkg::CMD_DPI_GET: begin
        if (p_addr_q == OW'(mcrr_pkg::ARG_BASE + 1)) resp_byte = dpi_x_q[15:8];
        if (p_addr_q == OW'(mcrr_pkg::ARG_BASE + 2)) resp_byte = dpi_x_q[7:0];
        if (p_addr_q == OW'(mcrr_pkg::ARG_BASE + 3)) resp_byte = dpi_y_q[15:8];
        if (p_addr_q == OW'(mcrr_pkg::ARG_BASE + 4)) resp_byte = dpi_y_q[7:0];
      end
      mcrr_pkg::CMD_STAGE_GET: begin
        if (p_addr_q == OW'(mcrr_pkg::ARG_BASE + 1)) resp_byte = active_q;
        if (p_addr_q == OW'(mcrr_pkg::ARG_BASE + 2)) resp_byte = 8'(stage_cnt_q);
        if (p_addr_q >= OW'(mcrr_pkg::REC_BASE) && rec_ok) begin
          resp_byte = 8'(rec_sel >> rec_sh);
        end
      end
      default: ;
    endcase
    if (p_addr_q == '0)                          resp_byte = wire_stat;
    if (p_addr_q == OW'(mcrr_pkg::CHECK_POS))    resp_byte = xor_q;
    if (p_addr_q == OW'(mcrr_pkg::LAST_POS))     resp_byte = 8'h00;
  end

  // pending result and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_wr) begin
      pend_rdata_q <= 8'h00;
      pend_exec_q  <= 1'b0;
      pend_stat_q  <= mcrr_pkg::STAT_NONE;
    end else if (cmd_i.pend_rd) begin
      pend_rdata_q <= (hold_rng_q && resp_ok_q) ? resp_rd : 8'h00;
      pend_exec_q  <= 1'b0;
      pend_stat_q  <= mcrr_pkg::STAT_NONE;
    end else if (cmd_i.pend_ex) begin
      pend_rdata_q <= 8'h00;
      pend_exec_q  <= 1'b1;
      pend_stat_q  <= st_q;
    end
    if (cmd_i.out_load) begin
      out_rdata_q <= pend_rdata_q;
      out_exec_q  <= pend_exec_q;
      out_stat_q  <= pend_stat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_rdata_o      = out_rdata_q;
  assign out_executed_o   = out_exec_q;
  assign out_cmd_status_o = out_stat_q;

endmodule

@@ src/mouse_control_report_responder_top.sv @@
// ----------------------------------------------------------------------------
// mouse_control_report_responder_top
// Device side of a 90-byte mouse command report: byte access and execution.
// ----------------------------------------------------------------------------
// One request is one byte access. A read or a write that does not hit the
// last offset passes its result through a pending register to the output
// register (reads first wait on the response buffer's registered read port);
// the next request is taken once the result sits in the output register. A
// write to the last offset runs the command: the request buffer, which has
// one read port, is walked twice (bytes 2..88 for the checksum and decode,
// then 0..89 to build the response). There is no clearing pass after reset;
// the response buffer reads as zero until the first command has run.
// ----------------------------------------------------------------------------
`include "mouse_control_report_responder_top_assert.svh"

module mouse_control_report_responder_top #(
  parameter int unsigned MAX_STAGES = mcrr_pkg::MAX_STAGES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  mcrr_req_if.sink   req_i,
  mcrr_rsp_if.source rsp_o
);

  mcrr_pkg::ctrl_cmd_t  cmd;
  mcrr_pkg::ctrl_stat_t stat;
  logic                 in_accept;

  // request is taken on valid and ready; ready is high only while idle
  assign in_accept = req_i.valid && req_i.ready;

  mcrr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_kind_i   (req_i.kind),
    .in_offset_i (req_i.offset),
    .in_ready_o  (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath holds both buffers, device settings and the output register
  mcrr_dp #(.MAX_STAGES(MAX_STAGES)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_accept_i      (in_accept),
    .in_kind_i        (req_i.kind),
    .in_offset_i      (req_i.offset),
    .in_wdata_i       (req_i.wdata),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_ready_i      (rsp_o.ready),
    .out_valid_o      (rsp_o.valid),
    .out_rdata_o      (rsp_o.rdata),
    .out_executed_o   (rsp_o.executed),
    .out_cmd_status_o (rsp_o.cmd_status)
  );

  // a final write starts the walk, so the next request must wait
  `MCRR_ASSERT_NEXT(a_exec_blocks, clk_i, rst_ni,
    in_accept && !req_i.kind && req_i.offset == 7'd89, !req_i.ready,
    "request taken during command execution")

  // an executed command always reports a status
  `MCRR_ASSERT_NOW(a_exec_status, clk_i, rst_ni,
    rsp_o.valid && rsp_o.executed, rsp_o.cmd_status != mcrr_pkg::STAT_NONE,
    "executed result without status")

  // plain accesses carry no status
  `MCRR_ASSERT_NOW(a_plain_status, clk_i, rst_ni,
    rsp_o.valid && !rsp_o.executed, rsp_o.cmd_status == mcrr_pkg::STAT_NONE,
    "status on a plain access")

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Command report responder testbench
// Directed table of requests, then random command reports, checked per result
// against a behavioral predictor of the responder.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import mcrr_pkg::*;

  localparam int unsigned N_STAGES  = 5;
  localparam int unsigned N_ITEMS   = 2000;
  localparam int unsigned CYC_LIMIT = 1500000;

  typedef struct packed {
    logic       kind;
    logic [6:0] offset;
    logic [7:0] wdata;
  } access_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       executed;
    logic [1:0] cmd_status;
  } answer_t;

  // directed row: access plus optional typed-in answer
  typedef struct packed {
    access_t acc;
    logic    has_ans;
    answer_t ans;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = CFG_FW_MAJOR;
  logic [7:0] cfg_wdata_i = '0;

  mcrr_req_if req_if ();
  mcrr_rsp_if rsp_if ();

  mouse_control_report_responder_top #(.MAX_STAGES(N_STAGES)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .req_i(req_if.sink), .rsp_o(rsp_if.source)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state
  // ---------------------------------------------------------------------------
  logic [7:0]  fw_major, fw_minor;
  logic [7:0]  req_buf [REPORT_BYTES];
  logic [7:0]  rsp_buf [REPORT_BYTES];
  logic [55:0] stage_rec [N_STAGES];
  logic [7:0]  stage_cnt, active_stage, poll_code;
  logic [15:0] dpi_x, dpi_y;

  answer_t pending_answers[$];
  answer_t typed_answers[$];   // parallel: typed answer, with its presence flag below
  bit      typed_flags[$];
  bit      failed = 1'b0;
  int      n_sent = 0;

  function automatic logic [7:0] span_xor(input logic [7:0] b [REPORT_BYTES]);
    logic [7:0] x;
    x = '0;
    for (int i = XOR_FIRST; i < CHECK_POS; i++) x ^= b[i];
    return x;
  endfunction

  // runs the command held in the request buffer, returns status code
  function automatic logic [1:0] run_report();
    logic [1:0] st;
    logic [7:0] cls, id, n;
    cls = req_buf[CLS_POS];
    id  = req_buf[ID_POS];
    st  = STAT_SUCCESS;
    for (int i = 0; i < CHECK_POS; i++) rsp_buf[i] = req_buf[i];
    rsp_buf[LAST_POS] = '0;
    if (span_xor(req_buf) != req_buf[CHECK_POS]) begin
      st = STAT_FAILURE;
    end else if (cls == CLS_SYS && id == ID_FW_GET) begin
      rsp_buf[ARG_BASE] = fw_major;
      rsp_buf[ARG_BASE+1] = fw_minor;
    end else if (cls == CLS_SYS && id == ID_POLL_GET) begin
      rsp_buf[ARG_BASE+1] = poll_code;
    end else if (cls == CLS_SYS && id == ID_POLL_SET) begin
      n = req_buf[ARG_BASE+1];
      if (n != 0 && (n & (n - 8'd1)) == 0 && n <= POLL_MAX) poll_code = n;
      else st = STAT_FAILURE;
    end else if (cls == CLS_DPI && id == ID_DPI_GET) begin
      {rsp_buf[ARG_BASE+1], rsp_buf[ARG_BASE+2]} = dpi_x;
      {rsp_buf[ARG_BASE+3], rsp_buf[ARG_BASE+4]} = dpi_y;
    end else if (cls == CLS_DPI && id == ID_DPI_SET) begin
      dpi_x = {req_buf[ARG_BASE+1], req_buf[ARG_BASE+2]};
      dpi_y = {req_buf[ARG_BASE+3], req_buf[ARG_BASE+4]};
    end else if (cls == CLS_DPI && id == ID_STAGE_GET) begin
      rsp_buf[ARG_BASE+1] = active_stage;
      rsp_buf[ARG_BASE+2] = stage_cnt;
      for (int i = 0; i < stage_cnt && i < N_STAGES; i++)
        for (int k = 0; k < REC_LEN; k++)
          rsp_buf[REC_BASE + i*REC_LEN + k] = stage_rec[i][8*(REC_LEN-1-k) +: 8];
    end else if (cls == CLS_DPI && id == ID_STAGE_SET) begin
      n = req_buf[ARG_BASE+2];
      if (n == 0 || n > N_STAGES) begin
        st = STAT_FAILURE;
      end else begin
        active_stage = req_buf[ARG_BASE+1];
        stage_cnt = n;
        for (int i = 0; i < n; i++)
          for (int k = 0; k < REC_LEN; k++)
            stage_rec[i][8*(REC_LEN-1-k) +: 8] = req_buf[REC_BASE + i*REC_LEN + k];
      end
    end else begin
      st = STAT_UNSUP;
    end
    rsp_buf[0] = (st == STAT_SUCCESS) ? WIRE_SUCCESS :
                 (st == STAT_FAILURE) ? WIRE_FAILURE : WIRE_UNSUP;
    rsp_buf[CHECK_POS] = span_xor(rsp_buf);
    return st;
  endfunction

  function automatic answer_t predict_access(input access_t a);
    answer_t r;
    r = '0;
    if (a.offset < REPORT_BYTES) begin
      if (a.kind) begin
        r.rdata = rsp_buf[a.offset];
      end else begin
        req_buf[a.offset] = a.wdata;
        if (a.offset == LAST_POS) begin
          r.executed = 1'b1;
          r.cmd_status = run_report();
        end
      end
    end
    return r;
  endfunction

  initial begin
    fw_major = FW_MAJOR_RST;
    fw_minor = FW_MINOR_RST;
    for (int i = 0; i < REPORT_BYTES; i++) begin
      req_buf[i] = '0;
      rsp_buf[i] = '0;
    end
    for (int i = 0; i < N_STAGES; i++) stage_rec[i] = '0;
    stage_cnt = STAGE_CNT_RST;
    active_stage = ACTIVE_RST;
    poll_code = POLL_RST;
    dpi_x = DPI_RST;
    dpi_y = DPI_RST;
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts and gaps; every accepted request is predicted right away
  // ---------------------------------------------------------------------------
  row_t    directed_q[$];
  bit      stim_done = 1'b0;
  int      burst_left = 0;

  initial begin
    req_if.valid = 1'b0;
    req_if.kind = 1'b0;
    req_if.offset = '0;
    req_if.wdata = '0;
  end

  task automatic send_access(input access_t a, input bit has_typed,
                             input answer_t typed);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      // valid drops only for a real gap; a burst keeps it high
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid  <= 1'b1;
    req_if.kind   <= a.kind;
    req_if.offset <= a.offset;
    req_if.wdata  <= a.wdata;
    do @(posedge clk_i); while (!req_if.ready);
    pending_answers.push_back(predict_access(a));
    typed_flags.push_back(has_typed);
    typed_answers.push_back(typed);
    n_sent++;
  endtask

  task automatic send_idle();
    req_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    send_idle();
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);  // quiet stretch before new settings
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_FW_MAJOR) fw_major = val;
    else fw_minor = val;
  endtask

  // build a full well-formed (or corrupted) report and send it byte by byte
  task automatic send_report(input logic [7:0] cls, input logic [7:0] id,
                             input bit bad_sum, input bit shuffle);
    logic [7:0] b [REPORT_BYTES];
    logic [7:0] x;
    int order [REPORT_BYTES-1];
    int j, t;
    access_t a;
    for (int i = 0; i < REPORT_BYTES; i++) b[i] = $urandom_range(0, 255);
    b[CLS_POS] = cls;
    b[ID_POS] = id;
    case ($urandom_range(0, 3))
      0: b[ARG_BASE+1] = 8'h01 << $urandom_range(0, 7);
      1: b[ARG_BASE+2] = $urandom_range(0, N_STAGES + 1);
      default: ;
    endcase
    x = '0;
    for (int i = XOR_FIRST; i < CHECK_POS; i++) x ^= b[i];
    b[CHECK_POS] = bad_sum ? (x ^ (8'h01 << $urandom_range(0, 7))) : x;
    for (int i = 0; i < REPORT_BYTES - 1; i++) order[i] = i;
    if (shuffle)
      for (int i = REPORT_BYTES - 2; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i]; order[i] = order[j]; order[j] = t;
      end
    for (int i = 0; i < REPORT_BYTES - 1; i++) begin
      a.kind = 1'b0; a.offset = order[i]; a.wdata = b[order[i]];
      send_access(a, 1'b0, '0);
      if ($urandom_range(0, 15) == 0) begin  // interleaved read noise
        a.kind = 1'b1; a.offset = $urandom_range(0, 127); a.wdata = $urandom;
        send_access(a, 1'b0, '0);
      end
    end
    a.kind = 1'b0; a.offset = LAST_POS; a.wdata = b[LAST_POS];
    send_access(a, 1'b0, '0);
    // read back some or all of the response
    for (int i = 0; i < REPORT_BYTES; i++)
      if ($urandom_range(0, 2) != 0) begin
        a.kind = 1'b1; a.offset = i; a.wdata = $urandom;
        send_access(a, 1'b0, '0);
      end
  endtask

  function automatic row_t mk_row(input logic k, input int off, input int wd,
                                  input bit typed, input int rd);
    row_t r;
    r.acc.kind = k; r.acc.offset = off; r.acc.wdata = wd;
    r.has_ans = typed;
    r.ans = '0;
    r.ans.rdata = rd;
    return r;
  endfunction

  logic [7:0] cmd_cls [8] = '{CLS_SYS, CLS_SYS, CLS_SYS, CLS_DPI, CLS_DPI,
                              CLS_DPI, CLS_DPI, 8'h07};
  logic [7:0] cmd_id  [8] = '{ID_FW_GET, ID_POLL_GET, ID_POLL_SET, ID_DPI_GET,
                              ID_DPI_SET, ID_STAGE_GET, ID_STAGE_SET, 8'h99};

  initial begin : stimulus
    row_t r;
    int rand_start;
    bit paused;
    // directed table: reads before any command give reset zeros, out-of-range
    // accesses give zeros, write extremes give no result data
    directed_q.push_back(mk_row(1, 0,   0,    1, 0));
    directed_q.push_back(mk_row(1, 89,  0,    1, 0));
    directed_q.push_back(mk_row(1, 90,  8'hff,1, 0));
    directed_q.push_back(mk_row(1, 127, 0,    1, 0));
    directed_q.push_back(mk_row(0, 127, 8'hff,1, 0));
    directed_q.push_back(mk_row(0, 90,  8'h00,1, 0));
    directed_q.push_back(mk_row(0, 0,   8'hff,1, 0));
    directed_q.push_back(mk_row(0, 0,   8'h00,1, 0));
    directed_q.push_back(mk_row(0, 88,  8'hff,1, 0));
    directed_q.push_back(mk_row(1, 45,  8'h5a,1, 0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_cfg(CFG_FW_MAJOR, 8'hff);
    write_cfg(CFG_FW_MINOR, 8'h00);

    foreach (directed_q[i]) send_access(directed_q[i].acc, directed_q[i].has_ans,
                                        directed_q[i].ans);
    // one report per operation, plus a bad checksum and an unknown command
    for (int c = 0; c < 8; c++) send_report(cmd_cls[c], cmd_id[c], 1'b0, 1'b0);
    send_report(CLS_SYS, ID_FW_GET, 1'b1, 1'b0);

    // sender pause until every result is back, then new settings
    wait_drained();
    write_cfg(CFG_FW_MAJOR, 8'h00);
    write_cfg(CFG_FW_MINOR, 8'hff);

    // random part: mostly well-formed reports, some noise and broken ones
    rand_start = n_sent;
    paused = 1'b0;
    while (n_sent < N_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          r.acc.kind = $urandom; r.acc.offset = $urandom_range(0, 127);
          r.acc.wdata = $urandom;
          if (r.acc.kind == 0 && r.acc.offset == LAST_POS) r.acc.offset = 0;
          send_access(r.acc, 1'b0, '0);
        end
        1: begin
          send_report($urandom_range(0, 5), $urandom, $urandom_range(0, 1), 1'b1);
        end
        default: begin
          send_report(cmd_cls[$urandom_range(0, 6)], cmd_id[$urandom_range(0, 6)],
                      $urandom_range(0, 7) == 0, $urandom_range(0, 1));
        end
      endcase
      if (!paused && n_sent >= rand_start + (N_ITEMS - rand_start) / 2) begin
        paused = 1'b1;
        wait_drained();
        write_cfg(CFG_FW_MAJOR, $urandom);
        write_cfg(CFG_FW_MINOR, $urandom);
      end
    end
    send_idle();
    stim_done = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern, plus one long hold-off
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int rx_count = 0;

  initial rsp_if.ready = 1'b0;

  always @(posedge clk_i) begin
    if (rx_count >= 30 && rx_count < 31 && stall_mode == 0) stall_mode = 1;
    case (stall_mode)
      1: begin
        // long hold-off: block must stall its input
        rsp_if.ready <= 1'b0;
        stall_mode = 2;
        fork begin repeat (300) @(posedge clk_i); stall_mode = 3; end join_none
      end
      2: rsp_if.ready <= 1'b0;
      default: rsp_if.ready <= ((rx_count / 64) % 3 == 0) ? 1'b1
                                : ($urandom_range(0, 3) != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    answer_t got, want, typed;
    bit      has_typed;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      rx_count++;
      got = {rsp_if.rdata, rsp_if.executed, rsp_if.cmd_status};
      if (pending_answers.size() == 0) begin
        $error("unexpected response: rdata %0h", got.rdata);
        failed = 1'b1;
      end else begin
        want = pending_answers.pop_front();
        typed = typed_answers.pop_front();
        has_typed = typed_flags.pop_front();
        if (has_typed && typed != want) begin
          $error("typed answer disagrees with predictor: exp %0h pred %0h",
                 typed, want);
          failed = 1'b1;
        end
        if (got.rdata !== want.rdata) begin
          $error("rdata: expected %0h actual %0h", want.rdata, got.rdata);
          failed = 1'b1;
        end
        if (got.executed !== want.executed) begin
          $error("executed: expected %0b actual %0b", want.executed, got.executed);
          failed = 1'b1;
        end
        if (got.cmd_status !== want.cmd_status) begin
          $error("cmd_status: expected %0d actual %0d", want.cmd_status,
                 got.cmd_status);
          failed = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // End of run and cycle limit
  // ---------------------------------------------------------------------------
  initial begin : finish_ctl
    int cycles;
    cycles = 0;
    while (!(stim_done && pending_answers.size() == 0) && cycles < CYC_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= CYC_LIMIT) begin
      $display("Verification failed");
    end else begin
      repeat (200) @(posedge clk_i);
      if (!failed && pending_answers.size() == 0) $display("Verification passed");
      else $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/mcrr_pkg.sv
src/mcrr_if.sv
src/mcrr_ram.sv
src/mcrr_ctrl.sv
src/mcrr_dp.sv
src/mouse_control_report_responder_top.sv
test/tb_top.sv
